[hdl/bmp_pkg.sv]
package bmp_pkg;

  // Event codes on the result channel
  typedef enum logic [2:0] {
    EV_NOTE_OFF      = 3'd0,
    EV_NOTE_ON       = 3'd1,
    EV_CTRL_CHANGE   = 3'd2,
    EV_PROG_CHANGE   = 3'd3,
    EV_PITCH_BEND    = 3'd4,
    EV_CH_AFTERTOUCH = 3'd5
  } evt_kind_e;

  // Upper nibble of channel voice statuses
  localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
  localparam logic [3:0] HI_NOTE_ON    = 4'h9;
  localparam logic [3:0] HI_CTRL       = 4'hB;
  localparam logic [3:0] HI_PROG       = 4'hC;
  localparam logic [3:0] HI_CH_PRESS   = 4'hD;
  localparam logic [3:0] HI_BEND       = 4'hE;

  localparam logic [7:0]  REALTIME_MIN = 8'hF8;
  localparam logic [7:0]  SYSTEM_MIN   = 8'hF0;
  localparam logic [15:0] BEND_OFFSET  = 16'd8192;

  typedef struct packed {
    logic [7:0] pkt_byte;
    logic       packet_start;
  } byte_t;

  typedef struct packed {
    evt_kind_e          event_kind;
    logic [4:0]         midi_channel;
    logic [7:0]         first_data;
    logic [7:0]         second_data;
    logic signed [15:0] bend_value;
  } event_t;

endpackage

[hdl/bmp_if.sv]
interface bmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] pkt_byte;
  logic       packet_start;

  modport source (output valid, output pkt_byte, output packet_start, input ready);
  modport sink   (input valid, input pkt_byte, input packet_start, output ready);
endinterface

interface bmp_event_if;
  logic               valid;
  logic               ready;
  logic [2:0]         event_kind;
  logic [4:0]         midi_channel;
  logic [7:0]         first_data;
  logic [7:0]         second_data;
  logic signed [15:0] bend_value;

  modport source (output valid, output event_kind, output midi_channel,
                  output first_data, output second_data, output bend_value,
                  input ready);
  modport sink   (input valid, input event_kind, input midi_channel,
                  input first_data, input second_data, input bend_value,
                  output ready);
endinterface

[hdl/ble_midi_packet_parser_core.sv]
// BLE MIDI packet parser. Packet bytes arrive one per transfer on in_i, with
// packet_start high on each packet's header byte; decoded channel voice events
// leave on evt_o. Each byte is held in an input register, parsed against a
// small parse state (phase, running status, one held data byte) and any
// resulting event is written to an output register. Throughput is one byte
// per clock while the output register is free or drains. The input register
// frees as soon as the output register can take its result. While an
// event waits untaken, the byte in the input register is held, whether or not
// it yields an event, so the input stalls once that register is full.
// Headers, timestamps, real-time, system common and SysEx bytes, poly
// aftertouch and filtered channels yield no event. cfg_we_i/cfg_wdata_i write
// the channel filter (0 passes all, 1..16 selects one channel); write it only
// while idle.
module ble_midi_packet_parser_core import bmp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [4:0]   cfg_wdata_i,
  bmp_byte_if.sink     in_i,
  bmp_event_if.source  evt_o
);

  logic [4:0] filter_q;
  logic       s1_valid_q;
  byte_t      s1_byte_q;
  logic       advance;
  logic       step;
  logic       emit;
  event_t     evt;
  logic       out_valid_q;
  event_t     out_q;

  // Channel filter register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_q <= '0;
    end else if (cfg_we_i) begin
      filter_q <= cfg_wdata_i;
    end
  end

  // The held byte may move on whenever the output register is free or drains
  assign advance  = !out_valid_q || evt_o.ready;
  assign step     = s1_valid_q && advance;
  assign in_i.ready = !s1_valid_q || advance;

  // Input register: hold the byte until it is parsed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= '{pkt_byte: in_i.pkt_byte, packet_start: in_i.packet_start};
    end
  end

  bmp_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (s1_byte_q),
    .filter_i (filter_q),
    .emit_o   (emit),
    .event_o  (evt)
  );

  // Output register: load on a parsed byte, drop the old event once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_q <= evt;
    end
  end

  assign evt_o.valid        = out_valid_q;
  assign evt_o.event_kind   = out_q.event_kind;
  assign evt_o.midi_channel = out_q.midi_channel;
  assign evt_o.first_data   = out_q.first_data;
  assign evt_o.second_data  = out_q.second_data;
  assign evt_o.bend_value   = out_q.bend_value;

  // An empty input register must always accept
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_i.ready)
    else $error("input register empty but not ready");

  // A parsed byte never overwrites an event still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !evt_o.ready) |-> !step)
    else $error("byte parsed while output stalled");

  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.midi_channel != 5'd0 && out_q.midi_channel <= 5'd16))
    else $error("channel out of range");

  a_bend_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.event_kind != EV_PITCH_BEND) |-> out_q.bend_value == 16'sd0)
    else $error("bend value on non-bend event");

  a_single_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.event_kind == EV_PROG_CHANGE ||
                     out_q.event_kind == EV_CH_AFTERTOUCH ||
                     out_q.event_kind == EV_PITCH_BEND)) |-> out_q.second_data == 8'd0)
    else $error("second data set on single-data event");

endmodule

[hdl/bmp_parse.sv]
module bmp_parse import bmp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,     // consume byte_i this cycle
  input  byte_t      byte_i,
  input  logic [4:0] filter_i,
  output logic       emit_o,
  output event_t     event_o
);

  localparam logic [2:0] PH_WAIT_HDR = 3'd0;
  localparam logic [2:0] PH_BOUNDARY = 3'd1;
  localparam logic [2:0] PH_AFTER_TS = 3'd2;
  localparam logic [2:0] PH_SKIP_SYS = 3'd3;
  localparam logic [2:0] PH_DATA     = 3'd4;

  logic [2:0] phase_q, phase_d;
  logic [7:0] status_q, status_d;
  logic [7:0] held_q, held_d;
  logic       pending_q, pending_d;

  logic [7:0] b;
  logic       high;
  logic       take;
  logic       need_two;
  logic [3:0] hi;
  logic [7:0] d1, d2;
  logic [4:0] chan;
  logic       pass;
  logic       kind_ok;

  assign b        = byte_i.pkt_byte;
  assign high     = b[7];
  assign hi       = status_q[7:4];
  assign need_two = !(hi == HI_PROG || hi == HI_CH_PRESS);
  assign chan     = {1'b0, status_q[3:0]} + 5'd1;
  assign pass     = (filter_i == 5'd0) || (filter_i == chan);

  always_comb begin
    phase_d   = phase_q;
    status_d  = status_q;
    held_d    = held_q;
    pending_d = pending_q;
    take      = 1'b0;
    d1        = '0;
    d2        = '0;
    kind_ok   = 1'b0;
    emit_o    = 1'b0;
    event_o   = '{event_kind: EV_NOTE_OFF, midi_channel: chan,
                  first_data: 8'd0, second_data: 8'd0, bend_value: 16'sd0};

    if (byte_i.packet_start) begin
      // Header: restart the parse and forget any partial message
      phase_d   = PH_BOUNDARY;
      status_d  = '0;
      held_d    = '0;
      pending_d = 1'b0;
    end else begin
      unique case (phase_q)
        PH_BOUNDARY: begin
          if (high) begin
            phase_d = PH_AFTER_TS;
          end else if (status_q != 8'd0) begin
            take = 1'b1;
          end
        end
        PH_AFTER_TS: begin
          if (high) begin
            if (b >= REALTIME_MIN) begin
              phase_d = PH_BOUNDARY;
            end else if (b >= SYSTEM_MIN) begin
              status_d = '0;
              phase_d  = PH_SKIP_SYS;
            end else begin
              status_d  = b;
              pending_d = 1'b0;
              phase_d   = PH_DATA;
            end
          end else if (status_q == 8'd0) begin
            phase_d = PH_BOUNDARY;
          end else begin
            take = 1'b1;
          end
        end
        PH_SKIP_SYS: begin
          if (high) begin
            phase_d = PH_AFTER_TS;
          end
        end
        PH_DATA: begin
          if (status_q == 8'd0) begin
            phase_d   = PH_BOUNDARY;
            pending_d = 1'b0;
          end else begin
            take = 1'b1;
          end
        end
        default: begin
          // waiting for a header: drop everything else
        end
      endcase
    end

    if (take) begin
      if (!pending_q && need_two) begin
        held_d    = b;
        pending_d = 1'b1;
        phase_d   = PH_DATA;
      end else begin
        d1        = pending_q ? held_q : b;
        d2        = pending_q ? b : 8'd0;
        held_d    = '0;
        pending_d = 1'b0;
        phase_d   = PH_BOUNDARY;
        event_o.first_data  = d1;
        event_o.second_data = d2;
        kind_ok = 1'b1;
        unique case (hi)
          HI_NOTE_OFF: event_o.event_kind = EV_NOTE_OFF;
          HI_NOTE_ON:  event_o.event_kind = (d2 == 8'd0) ? EV_NOTE_OFF : EV_NOTE_ON;
          HI_CTRL:     event_o.event_kind = EV_CTRL_CHANGE;
          HI_PROG: begin
            event_o.event_kind  = EV_PROG_CHANGE;
            event_o.second_data = 8'd0;
          end
          HI_CH_PRESS: begin
            event_o.event_kind  = EV_CH_AFTERTOUCH;
            event_o.second_data = 8'd0;
          end
          HI_BEND: begin
            event_o.event_kind  = EV_PITCH_BEND;
            event_o.first_data  = 8'd0;
            event_o.second_data = 8'd0;
            event_o.bend_value  = (({1'b0, d2, 7'd0} | {8'd0, d1}) - BEND_OFFSET);
          end
          default: kind_ok = 1'b0; // poly aftertouch: consume silently
        endcase
        emit_o = kind_ok && pass;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_WAIT_HDR;
      status_q  <= '0;
      held_q    <= '0;
      pending_q <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      status_q  <= status_d;
      held_q    <= held_d;
      pending_q <= pending_d;
    end
  end

endmodule
